@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
// each macro samples on clk and is switched off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define UBL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define UBL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ubl_pkg.sv @@
// types, codes and helpers of the uart boot image loader
// no dependencies; imported by every module of the block
`default_nettype none

package ubl_pkg;

	// protocol characters
	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_ACK = 8'h06;

	// request kinds
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_RX    = 2'd1;
	localparam logic [1:0] REQ_CODE  = 2'd2;

	// configuration register indexes
	localparam logic CFG_IMAGE_LENGTH   = 1'b0;
	localparam logic CFG_STX_WAIT_LIMIT = 1'b1;

	localparam logic [15:0] IMAGE_LENGTH_RST   = 16'd1;
	localparam logic [9:0]  STX_WAIT_LIMIT_RST = 10'd320;

	// reported status
	localparam logic [1:0] STATUS_IDLE = 2'd0;
	localparam logic [1:0] STATUS_BUSY = 2'd1;
	localparam logic [1:0] STATUS_DONE = 2'd2;
	localparam logic [1:0] STATUS_FAIL = 2'd3;

	// reported failing step
	localparam logic [2:0] STEP_NONE = 3'd0;
	localparam logic [2:0] STEP_STX  = 3'd2;
	localparam logic [2:0] STEP_ACK  = 3'd4;
	localparam logic [2:0] STEP_SUM  = 3'd6;

	// beat index of the final result of a request
	localparam logic [1:0] BEAT_FIRST = 2'd0;
	localparam logic [1:0] BEAT_THIRD = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_WAIT_STX,
		PH_WAIT_ACK,
		PH_SEND,
		PH_WAIT_SUM,
		PH_DONE,
		PH_FAIL_STX,
		PH_FAIL_ACK,
		PH_FAIL_SUM
	} phase_t;

	// configuration seen by the protocol logic
	typedef struct packed {
		logic [15:0] image_length;
		logic [9:0]  stx_wait_limit;
	} cfg_t;

	// all results caused by one request
	typedef struct packed {
		logic [1:0] last_beat;
		logic       tx_valid;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [1:0] status;
		logic [2:0] fail_step;
		logic       want_code;
	} bundle_t;

	function automatic logic [1:0] phase_status(input phase_t ph);
		logic [1:0] st;
		unique case (ph)
			PH_IDLE:                             st = STATUS_IDLE;
			PH_DONE:                             st = STATUS_DONE;
			PH_FAIL_STX, PH_FAIL_ACK, PH_FAIL_SUM: st = STATUS_FAIL;
			default:                             st = STATUS_BUSY;
		endcase
		return st;
	endfunction

	function automatic logic [2:0] phase_fail_step(input phase_t ph);
		logic [2:0] fs;
		unique case (ph)
			PH_FAIL_STX: fs = STEP_STX;
			PH_FAIL_ACK: fs = STEP_ACK;
			PH_FAIL_SUM: fs = STEP_SUM;
			default:     fs = STEP_NONE;
		endcase
		return fs;
	endfunction

endpackage

`default_nettype wire

@@ rtl/ubl_cfg.sv @@
// configuration registers of the boot image loader
// depends on ubl_pkg for register indexes and reset values
`default_nettype none

module ubl_cfg
	import ubl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_addr,
	input  wire logic [15:0] cfg_data,
	output cfg_t             cfg
);

	logic [15:0] image_length_q;
	logic [9:0]  stx_wait_limit_q;

	// writes are always taken
	assign cfg_ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_length_q   <= IMAGE_LENGTH_RST;
			stx_wait_limit_q <= STX_WAIT_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				CFG_IMAGE_LENGTH:   image_length_q   <= cfg_data;
				CFG_STX_WAIT_LIMIT: stx_wait_limit_q <= cfg_data[9:0];
				default:            ;
			endcase
		end
	end

	assign cfg.image_length   = image_length_q;
	assign cfg.stx_wait_limit = stx_wait_limit_q;

endmodule

`default_nettype wire

@@ rtl/ubl_step.sv @@
// protocol state and per-request next-state logic of the boot image loader
// depends on ubl_pkg for phases, codes and the result bundle type
`default_nettype none

module ubl_step
	import ubl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire logic [1:0] req_type,
	input  wire logic [7:0] rx_byte,
	input  wire logic [7:0] code_byte,
	input  wire cfg_t       cfg,
	output bundle_t         bundle
);

	phase_t      phase_q, phase_d;
	logic [15:0] bytes_sent_q, bytes_sent_d;
	logic [7:0]  xor_sum_q, xor_sum_d;
	logic [9:0]  stx_wait_count_q, stx_wait_count_d;
	logic [15:0] bytes_inc;
	logic [7:0]  xor_next;

	assign bytes_inc = bytes_sent_q + 16'd1;
	assign xor_next  = xor_sum_q ^ code_byte;

	// state registers, updated once per handled request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			bytes_sent_q     <= '0;
			xor_sum_q        <= '0;
			stx_wait_count_q <= '0;
		end else if (load) begin
			phase_q          <= phase_d;
			bytes_sent_q     <= bytes_sent_d;
			xor_sum_q        <= xor_sum_d;
			stx_wait_count_q <= stx_wait_count_d;
		end
	end

	// protocol decision for the pending request
	always_comb begin
		phase_d          = phase_q;
		bytes_sent_d     = bytes_sent_q;
		xor_sum_d        = xor_sum_q;
		stx_wait_count_d = stx_wait_count_q;
		bundle.last_beat = BEAT_FIRST;
		bundle.tx_valid  = 1'b0;
		bundle.byte0     = '0;
		bundle.byte1     = '0;
		bundle.byte2     = '0;
		priority if (req_type == REQ_START) begin
			phase_d          = PH_WAIT_STX;
			bytes_sent_d     = '0;
			xor_sum_d        = '0;
			stx_wait_count_d = '0;
		end else if (req_type == REQ_RX && phase_q == PH_WAIT_STX) begin
			if (rx_byte == CH_STX) begin
				// announce the image: start of header then length low, high
				phase_d          = PH_WAIT_ACK;
				bundle.last_beat = BEAT_THIRD;
				bundle.tx_valid  = 1'b1;
				bundle.byte0     = CH_SOH;
				bundle.byte1     = cfg.image_length[7:0];
				bundle.byte2     = cfg.image_length[15:8];
			end else if (stx_wait_count_q >= cfg.stx_wait_limit) begin
				phase_d = PH_FAIL_STX;
			end else begin
				stx_wait_count_d = stx_wait_count_q + 10'd1;
			end
		end else if (req_type == REQ_RX && phase_q == PH_WAIT_ACK) begin
			if (rx_byte == CH_ACK) begin
				phase_d      = PH_SEND;
				bytes_sent_d = '0;
				xor_sum_d    = '0;
			end else begin
				phase_d = PH_FAIL_ACK;
			end
		end else if (req_type == REQ_RX && phase_q == PH_WAIT_SUM) begin
			if (rx_byte == xor_sum_q) begin
				phase_d         = PH_DONE;
				bundle.tx_valid = 1'b1;
				bundle.byte0    = CH_ACK;
			end else begin
				phase_d = PH_FAIL_SUM;
			end
		end else if (req_type == REQ_CODE && phase_q == PH_SEND) begin
			// forward the image byte and fold it into the checksum
			xor_sum_d       = xor_next;
			bytes_sent_d    = bytes_inc;
			bundle.tx_valid = 1'b1;
			bundle.byte0    = code_byte;
			if (bytes_inc >= cfg.image_length) begin
				phase_d = PH_WAIT_SUM;
			end
		end else begin
			// request with no meaning in this phase: status only
		end
		bundle.status    = phase_status(phase_d);
		bundle.fail_step = phase_fail_step(phase_d);
		bundle.want_code = (phase_d == PH_SEND);
	end

endmodule

`default_nettype wire

@@ rtl/ubl_out.sv @@
// result buffer of the boot image loader, one byte per beat, one or three beats per result on the stream
// depends on ubl_pkg for the result bundle type
`default_nettype none

module ubl_out
	import ubl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire bundle_t     bundle,
	output logic             free,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,
	output logic             m_tuser,
	output logic             m_tlast
);

	bundle_t    bundle_q;
	logic       valid_q;
	logic [1:0] beat_q;
	logic       last_beat;
	logic [7:0] tx_byte;

	assign last_beat = (beat_q == bundle_q.last_beat);
	assign free      = !valid_q || (m_tready && last_beat);

	// buffer occupancy and beat counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= BEAT_FIRST;
		end else if (load) begin
			valid_q <= 1'b1;
			beat_q  <= BEAT_FIRST;
		end else if (valid_q && m_tready) begin
			if (last_beat) begin
				valid_q <= 1'b0;
			end else begin
				beat_q <= beat_q + 2'd1;
			end
		end
	end

	// results of the request in flight
	always_ff @(posedge clk) begin
		if (load) begin
			bundle_q <= bundle;
		end
	end

	// byte for the current beat
	always_comb begin
		unique case (beat_q)
			2'd1:    tx_byte = bundle_q.byte1;
			2'd2:    tx_byte = bundle_q.byte2;
			default: tx_byte = bundle_q.byte0;
		endcase
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = bundle_q.tx_valid;
	assign m_tlast  = last_beat;
	assign m_tdata  = {2'b00, bundle_q.want_code, bundle_q.fail_step, bundle_q.status, tx_byte};

endmodule

`default_nettype wire

@@ rtl/uart_boot_image_loader_core.sv @@
// top level of the uart boot image loader (host side of a boot download)
// depends on ubl_pkg, ubl_cfg, ubl_step and ubl_out
//
// channel   direction  handshake              payload
// s_*       in         s_tvalid / s_tready    tuser: req_type; tdata: rx_byte, code_byte
// m_*       out        m_tvalid / m_tready    tuser: tx_valid; tdata: tx_byte, status,
//                                              fail_step, want_code; tlast: last
// cfg_*     in         cfg_valid / cfg_ready  cfg_addr: register index; cfg_data: value
//
// a request is held in the input register, then is handled when the result buffer is free
// and its results go to the result buffer; one request per cycle is sustained
// while each request yields one result and m_tready stays high, an STX reply yields three beats
// the three-beat result buffer sets the rate under output stalls
// arst_n clears the protocol state to idle and loads the register reset values
`default_nettype none

module uart_boot_image_loader_core
	import ubl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [7:0] rx_byte, [15:8] code_byte
	input  wire logic [1:0]  s_tuser,   // [1:0] req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] tx_byte, [9:8] status, [12:10] fail_step,
	                                    // [13] want_code, [15:14] zero
	output logic             m_tuser,   // [0] tx_valid
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_addr,
	input  wire logic [15:0] cfg_data
);

	cfg_t       cfg;
	bundle_t    bundle;
	logic       valid_s1;
	logic [1:0] req_type_s1;
	logic [7:0] rx_byte_s1;
	logic [7:0] code_byte_s1;
	logic       out_free;
	logic       load;

	// request handled when the result buffer can take its results
	assign load     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_type_s1  <= s_tuser;
			rx_byte_s1   <= s_tdata[7:0];
			code_byte_s1 <= s_tdata[15:8];
		end
	end

	ubl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ubl_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.req_type  (req_type_s1),
		.rx_byte   (rx_byte_s1),
		.code_byte (code_byte_s1),
		.cfg       (cfg),
		.bundle    (bundle)
	);

	ubl_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.bundle   (bundle),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

@@ rtl/ubl_checker.sv @@
// port-level checks of the uart boot image loader, bound to the top level
// depends on ubl_pkg for status codes and on assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module ubl_checker
	import ubl_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);

	logic        out_stall;
	logic [17:0] out_beat;
	logic        out_quiet;
	logic        out_failed;
	logic        out_has_step;
	logic        out_asking;
	logic        out_busy;

	// fields of the result on the stream
	assign out_stall    = m_tvalid && !m_tready;
	assign out_beat     = {m_tlast, m_tuser, m_tdata};
	assign out_quiet    = m_tvalid && !m_tuser;
	assign out_failed   = (m_tdata[9:8] == STATUS_FAIL);
	assign out_has_step = (m_tdata[12:10] != STEP_NONE);
	assign out_asking   = m_tvalid && m_tdata[13];
	assign out_busy     = (m_tdata[9:8] == STATUS_BUSY);

	// a stalled result stays put
	`UBL_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(out_beat), "stalled result changed")

	// nothing to send means a zero byte
	`UBL_ASSERT_SAME(a_tx_zero, out_quiet, m_tdata[7:0] == 8'h00, "tx_byte without tx_valid")

	// a failing step is reported exactly when the run has failed
	`UBL_ASSERT_SAME(a_fail_step, m_tvalid, out_failed == out_has_step, "fail_step against status")

	// image bytes are only asked for while the download runs
	`UBL_ASSERT_SAME(a_want_busy, out_asking, out_busy, "want_code outside a running download")

endmodule

bind uart_boot_image_loader_core ubl_checker u_ubl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
